>>> hdl/mcct_pkg.sv
// Shared types and constants for the minimum coin change table block.
package mcct_pkg;

  localparam int AMT_W         = 6;
  localparam int CNT_W         = 7;
  localparam int COIN_W        = 6;
  localparam int NCOIN_W       = 3;
  localparam int NUM_COIN_REGS = 4;
  localparam int CIDX_W        = $clog2(NUM_COIN_REGS);
  localparam int MAX_COINS     = 4;
  localparam int MAX_AMOUNT    = 63;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 6;
  localparam int S_DATA_W      = 8;
  localparam int M_DATA_W      = 16;

  localparam logic [CNT_W-1:0] UNREACH = 7'd127;

  localparam logic [CFG_IDX_W-1:0] REG_COIN0        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COIN1        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COIN2        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COIN3        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COINS_IN_USE = 3'd4;

  typedef logic [NUM_COIN_REGS-1:0][COIN_W-1:0] coin_set_t;

  typedef struct packed {
    logic             we;
    logic [AMT_W-1:0] waddr;
    logic [CNT_W-1:0] wdata;
    logic [AMT_W-1:0] raddr_a;
    logic [AMT_W-1:0] raddr_b;
  } ram_req_t;

  typedef struct packed {
    logic             last;
    logic             reach;
    logic [AMT_W-1:0] count;
    logic [AMT_W-1:0] amount;
  } out_word_t;

endpackage

>>> hdl/mcct_table_ram.sv
// Count table memory: one write port, two registered read ports.
module mcct_table_ram #(
  parameter int DEPTH = mcct_pkg::MAX_AMOUNT + 1,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  mcct_pkg::ram_req_t           req,
  output logic [mcct_pkg::CNT_W-1:0]   rdata_a,
  output logic [mcct_pkg::CNT_W-1:0]   rdata_b
);

  logic [mcct_pkg::CNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    rdata_a <= mem[req.raddr_a[AW-1:0]];
    rdata_b <= mem[req.raddr_b[AW-1:0]];
  end

endmodule

>>> hdl/mcct_out_buf.sv
// Two-entry result buffer with a room flag for read-ahead.
module mcct_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mcct_pkg::out_word_t   push_word,
  output logic                  room,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output mcct_pkg::out_word_t   head
);

  mcct_pkg::out_word_t ent [2];
  logic [1:0] cnt;
  logic       rptr;
  logic       wptr;
  logic       pop;
  logic [2:0] occ_next;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (cnt != 2'd0);
  assign head     = ent[rptr];
  assign occ_next = {1'b0, cnt} + {2'b00, push} - {2'b00, pop};
  assign room     = (occ_next <= 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 2'd0;
      rptr <= 1'b0;
      wptr <= 1'b0;
    end else begin
      cnt <= occ_next[1:0];
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= push_word;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && cnt == 2'd2 && !pop))
    else $error("result buffer overflow");

endmodule

>>> hdl/mcct_ctrl.sv
// Sequencer: table clear, per-coin relaxation with forwarding, table readout.
module mcct_ctrl #(
  parameter int MAX_AMOUNT = mcct_pkg::MAX_AMOUNT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_valid,
  output logic                            s_ready,
  input  logic [mcct_pkg::AMT_W-1:0]      target,
  input  mcct_pkg::coin_set_t             coins,
  input  logic [mcct_pkg::NCOIN_W-1:0]    coins_in_use,
  output mcct_pkg::ram_req_t              req,
  input  logic [mcct_pkg::CNT_W-1:0]      ram_a,
  input  logic [mcct_pkg::CNT_W-1:0]      ram_b,
  output logic                            push,
  output mcct_pkg::out_word_t             push_word,
  input  logic                            room
);

  typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_COIN, S_RELAX, S_OUT} state_t;

  state_t                        state;
  logic [mcct_pkg::AMT_W-1:0]    tgt;
  logic [mcct_pkg::NCOIN_W-1:0]  ncoins;
  logic [mcct_pkg::NCOIN_W-1:0]  cidx;
  logic [mcct_pkg::AMT_W-1:0]    j;
  logic [mcct_pkg::COIN_W-1:0]   v;
  logic                          p_vld;
  logic [mcct_pkg::AMT_W-1:0]    ra_q;
  logic [mcct_pkg::AMT_W-1:0]    rb_q;
  logic                          fwd_en;
  logic [mcct_pkg::AMT_W-1:0]    fwd_addr;
  logic [mcct_pkg::CNT_W-1:0]    fwd_data;
  logic                          rd_pend;
  logic [mcct_pkg::AMT_W-1:0]    o_amt;
  logic                          o_last;

  logic [mcct_pkg::COIN_W-1:0]   cur_v;
  logic                          issue_relax;
  logic                          issue_out;
  logic [mcct_pkg::CNT_W-1:0]    rda;
  logic [mcct_pkg::CNT_W-1:0]    rdb;
  logic [mcct_pkg::CNT_W-1:0]    cand;
  logic [mcct_pkg::CNT_W-1:0]    relaxed;
  logic [mcct_pkg::AMT_W-1:0]    tgt_sat;
  logic [mcct_pkg::NCOIN_W-1:0]  ncoins_sat;

  assign s_ready     = (state == S_IDLE);
  assign cur_v       = coins[cidx[mcct_pkg::CIDX_W-1:0]];
  assign issue_relax = (state == S_RELAX);
  assign issue_out   = (state == S_OUT) && room;

  assign rda = (fwd_en && fwd_addr == ra_q) ? fwd_data : ram_a;
  assign rdb = (fwd_en && fwd_addr == rb_q) ? fwd_data : ram_b;

  assign cand    = rda + 7'd1;
  assign relaxed = (rda != mcct_pkg::UNREACH && cand < rdb) ? cand : rdb;

  always_comb begin
    tgt_sat = target;
    if (target > mcct_pkg::AMT_W'(MAX_AMOUNT)) begin
      tgt_sat = mcct_pkg::AMT_W'(MAX_AMOUNT);
    end
    ncoins_sat = coins_in_use;
    if (int'(ncoins_sat) > mcct_pkg::NUM_COIN_REGS) begin
      ncoins_sat = mcct_pkg::NCOIN_W'(mcct_pkg::NUM_COIN_REGS);
    end
    if (int'(ncoins_sat) > mcct_pkg::MAX_COINS) begin
      ncoins_sat = mcct_pkg::NCOIN_W'(mcct_pkg::MAX_COINS);
    end
  end

  always_comb begin
    req.raddr_a = issue_out ? j : (j - mcct_pkg::AMT_W'(v));
    req.raddr_b = j;
    req.we      = 1'b0;
    req.waddr   = rb_q;
    req.wdata   = relaxed;
    if (state == S_CLEAR) begin
      req.we    = 1'b1;
      req.waddr = j;
      req.wdata = (j == '0) ? '0 : mcct_pkg::UNREACH;
    end else if (p_vld) begin
      req.we = 1'b1;
    end
  end

  assign push             = rd_pend;
  assign push_word.amount = o_amt;
  assign push_word.reach  = (rda != mcct_pkg::UNREACH);
  assign push_word.count  = (rda != mcct_pkg::UNREACH) ? rda[mcct_pkg::AMT_W-1:0] : '0;
  assign push_word.last   = o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      p_vld   <= 1'b0;
      fwd_en  <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      p_vld   <= issue_relax;
      fwd_en  <= req.we;
      rd_pend <= issue_out;
      unique case (state)
        S_IDLE: begin
          if (s_valid) begin
            tgt    <= tgt_sat;
            ncoins <= ncoins_sat;
            j      <= '0;
            state  <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (j == tgt) begin
            cidx  <= '0;
            state <= S_COIN;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_COIN: begin
          if (cidx == ncoins) begin
            j     <= '0;
            state <= S_OUT;
          end else if (cur_v == '0 || cur_v > tgt) begin
            cidx <= cidx + 1'b1;
          end else begin
            v     <= cur_v;
            j     <= cur_v;
            state <= S_RELAX;
          end
        end
        S_RELAX: begin
          if (j == tgt) begin
            cidx  <= cidx + 1'b1;
            state <= S_COIN;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_OUT: begin
          if (room) begin
            if (j == tgt) begin
              state <= S_IDLE;
            end else begin
              j <= j + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ra_q     <= req.raddr_a;
    rb_q     <= req.raddr_b;
    fwd_addr <= req.waddr;
    fwd_data <= req.wdata;
    o_amt    <= j;
    o_last   <= (j == tgt);
  end

  a_no_wb_in_clear: assert property (@(posedge clk) disable iff (rst)
    !(p_vld && state == S_CLEAR))
    else $error("relax write-back during table clear");

  a_out_after_wb: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> !p_vld)
    else $error("readout started with relax write-back pending");

  a_relax_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RELAX |-> (j >= v && j <= tgt && v != '0))
    else $error("relax index out of range");

endmodule

>>> hdl/min_coin_change_table_top.sv
// Top level of the minimum coin change table block.
//
//  port group   dir  word layout (low bit first)                  accepted when
//  s_*          in   tdata: target_amount[5:0]                     s_tvalid & s_tready
//  m_*          out  tdata: amount_index, coin_count; tuser: reach m_tvalid & m_tready
//  cfg_*        in   cfg_data: register value, cfg_index: reg      cfg_we
//
//  A request with target T clears table entries 0 to T, relaxes them once for each
//  coin in use that is nonzero and not above T, then reads entries 0 to T out; the
//  table memory has a single write port.
//  Reset is synchronous; table contents are not cleared by reset.
//  m_tready low stalls readout through a two-entry result buffer; a new request
//  is taken once the previous readout has been issued.
module min_coin_change_table_top #(
  parameter int MAX_AMOUNT = mcct_pkg::MAX_AMOUNT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mcct_pkg::S_DATA_W-1:0]       s_tdata,   // target_amount
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mcct_pkg::M_DATA_W-1:0]       m_tdata,   // amount_index, coin_count
  output logic                                m_tuser,   // reachable
  output logic                                m_tlast,
  input  logic                                cfg_we,
  input  logic [mcct_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mcct_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mcct_pkg::coin_set_t                coins;
  logic [mcct_pkg::NCOIN_W-1:0]       coins_in_use;
  mcct_pkg::ram_req_t                 req;
  logic [mcct_pkg::CNT_W-1:0]         ram_a;
  logic [mcct_pkg::CNT_W-1:0]         ram_b;
  logic                               push;
  mcct_pkg::out_word_t                push_word;
  logic                               room;
  mcct_pkg::out_word_t                head;

  always_ff @(posedge clk) begin
    if (rst) begin
      coins[0]     <= 6'd16;
      coins[1]     <= 6'd10;
      coins[2]     <= 6'd5;
      coins[3]     <= 6'd1;
      coins_in_use <= 3'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcct_pkg::REG_COIN0:        coins[0]     <= cfg_data;
        mcct_pkg::REG_COIN1:        coins[1]     <= cfg_data;
        mcct_pkg::REG_COIN2:        coins[2]     <= cfg_data;
        mcct_pkg::REG_COIN3:        coins[3]     <= cfg_data;
        mcct_pkg::REG_COINS_IN_USE: coins_in_use <= cfg_data[mcct_pkg::NCOIN_W-1:0];
        default: ;
      endcase
    end
  end

  mcct_ctrl #(
    .MAX_AMOUNT (MAX_AMOUNT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_valid      (s_tvalid),
    .s_ready      (s_tready),
    .target       (s_tdata[mcct_pkg::AMT_W-1:0]),
    .coins        (coins),
    .coins_in_use (coins_in_use),
    .req          (req),
    .ram_a        (ram_a),
    .ram_b        (ram_b),
    .push         (push),
    .push_word    (push_word),
    .room         (room)
  );

  mcct_table_ram #(
    .DEPTH (MAX_AMOUNT + 1)
  ) u_ram (
    .clk     (clk),
    .req     (req),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  mcct_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .room      (room),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .head      (head)
  );

  assign m_tdata = {4'b0000, head.count, head.amount};
  assign m_tuser = head.reach;
  assign m_tlast = head.last;

endmodule
